>>> hdl/box3x3_detail_mask_assert.svh
// Assertion macros for the 3x3 detail mask block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BOX3X3_DETAIL_MASK_ASSERT_SVH
`define BOX3X3_DETAIL_MASK_ASSERT_SVH

// Same-cycle implication.
`define BOX3DM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BOX3DM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/box3dm_pkg.sv
// Shared types and constants of the 3x3 detail mask block.
// No dependencies.
`timescale 1ns / 1ps

package box3dm_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned ROW_W  = DIM_W;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  localparam int unsigned BOX_N     = 3;
  localparam int unsigned CSUM_W    = 10;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned RECIP_W   = 13;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned MEAN_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] RST_WIDTH  = (DIM_W'(1024) > DIM_MAX_W) ? DIM_MAX_W
                                                                       : DIM_W'(1024);
  localparam logic [DIM_W-1:0] RST_HEIGHT = (DIM_W'(1024) > DIM_MAX_H) ? DIM_MAX_H
                                                                       : DIM_W'(1024);

  // register index taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel;
    logic is_pad;
  } in_beat_t;

  typedef struct packed {
    pix_t detail;
    logic last_of_frame;
  } out_beat_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

endpackage

>>> hdl/box3x3_detail_mask.sv
// Top level of the 3x3 detail mask block: position tracking, line store,
// window cell chain and the mean / difference pipeline.
// Depends on box3dm_pkg, box3dm_ram, box3dm_cell.
//
// Usage: grey pixels enter in raster order on the in channel (valid/ready),
// one beat per pixel. Each interior pixel yields |floor(box sum / 9) - center|,
// border pixels yield their own value, on the out channel (valid/ready).
// A result belongs to the pixel one row plus one column before the input
// that completes its window, so width + 1 beats (pad beats serve) follow a
// frame to drain it; last_of_frame marks the final result, after which the
// next beat starts a new frame.
// Throughput: one beat per cycle while the receiver takes results, set by the
// single line store RAM that is read and written once per beat. An accepted
// beat reaches the result it completes through the RAM read, window shift,
// sum, mean and difference registers.
// Reset clears position and pipeline; width and height come up at 1024.
// A write of either register restarts the frame. When the receiver stalls,
// the result holds in the output register and upstream stages keep filling
// until no bubble is left, then in_ready_o drops.
`timescale 1ns / 1ps

module box3x3_detail_mask (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  box3dm_pkg::in_beat_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output box3dm_pkg::out_beat_t                out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [box3dm_pkg::PADDR_W-1:0]       paddr,
  input  logic [box3dm_pkg::DATA_W-1:0]        pwdata,
  output logic [box3dm_pkg::DATA_W-1:0]        prdata,
  output logic                                 pready
);
  import box3dm_pkg::*;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } flags_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration
  logic             cfg_we;
  logic [DIM_W-1:0] width_q, width_d, height_q, height_d;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we) begin
      unique case (paddr[2])
        REG_WIDTH:  width_d  = clamp_dim(pwdata[DIM_W-1:0], DIM_MAX_W);
        REG_HEIGHT: height_d = clamp_dim(pwdata[DIM_W-1:0], DIM_MAX_H);
        default:    width_d  = width_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(height_q) : DATA_W'(width_q);

  // handshake chain
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic go_out, go4, go3, go2, go1;
  logic accept, mv12, mv23, mv34, mv4o;

  assign go_out = !out_valid_q || out_ready_i;
  assign go4    = !s4_valid_q || go_out;
  assign go3    = !s3_valid_q || go4;
  assign go2    = !s2_valid_q || go3;
  assign go1    = !s1_valid_q || go2;

  assign in_ready_o = go1;
  assign accept     = in_valid_i && go1;
  assign mv12       = s1_valid_q && go2;
  assign mv23       = s2_valid_q && go3;
  assign mv34       = s3_valid_q && go4;
  assign mv4o       = s4_valid_q && go_out;

  // position of the next beat
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             col_is0, end_of_row;
  flags_t           flags_in;

  assign col_is0    = (col_q == '0);
  assign end_of_row = (DIM_W'(col_q) + DIM_W'(1)) == width_q;

  always_comb begin
    flags_in.emit   = col_is0 ? (row_q >= ROW_W'(2)) : (row_q >= ROW_W'(1));
    flags_in.last   = col_is0 && (row_q == ROW_W'(height_q) + ROW_W'(1));
    flags_in.border = col_is0 || (row_q == ROW_W'(1)) || (row_q >= ROW_W'(height_q))
                      || (col_q == COL_W'(1));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (flags_in.last) begin
        col_d = '0;
        row_d = '0;
      end else if (end_of_row) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // stage 1: line store read in flight
  pix_t             s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  flags_t           s1_flags_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= in_data_i.is_pad ? '0 : in_data_i.pixel;
      s1_col_q   <= col_q;
      s1_flags_q <= flags_in;
    end
  end

  logic [2*PIX_W-1:0] line_rdata, line_wdata;
  col_t               new_col;

  assign new_col.top = line_rdata[2*PIX_W-1:PIX_W];
  assign new_col.mid = line_rdata[PIX_W-1:0];
  assign new_col.bot = s1_pix_q;
  assign line_wdata  = {new_col.mid, new_col.bot};

  box3dm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mv12),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // stage 2: window cell chain, oldest column in cell 0
  col_t              cell_in  [BOX_N];
  col_t              cell_col [BOX_N];
  logic [CSUM_W-1:0] cell_sum [BOX_N];
  flags_t            s2_flags_q;

  for (genvar k = 0; k < BOX_N; k++) begin : g_cell
    if (k == BOX_N - 1) begin : g_head
      assign cell_in[k] = new_col;
    end else begin : g_link
      assign cell_in[k] = cell_col[k+1];
    end
    box3dm_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (mv12),
      .col_i   (cell_in[k]),
      .col_o   (cell_col[k]),
      .sum_o   (cell_sum[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (mv12) begin
      s2_flags_q <= s1_flags_q;
    end
  end

  // stage 3: box sum
  logic [SUM_W-1:0] box_sum, s3_sum_q;
  pix_t             s3_center_q;
  logic             s3_border_q, s3_last_q;

  assign box_sum = SUM_W'(cell_sum[0]) + SUM_W'(cell_sum[1]) + SUM_W'(cell_sum[2]);

  always_ff @(posedge clk_i) begin
    if (mv23) begin
      s3_sum_q    <= box_sum;
      s3_center_q <= cell_col[BOX_N/2].mid;
      s3_border_q <= s2_flags_q.border;
      s3_last_q   <= s2_flags_q.last;
    end
  end

  // stage 4: floor(sum / 9) by reciprocal
  logic [PROD_W-1:0] prod;
  pix_t              s4_mean_q, s4_center_q;
  logic              s4_border_q, s4_last_q;

  assign prod = PROD_W'(s3_sum_q) * PROD_W'(RECIP_9);

  always_ff @(posedge clk_i) begin
    if (mv34) begin
      s4_mean_q   <= prod[MEAN_SHIFT +: PIX_W];
      s4_center_q <= s3_center_q;
      s4_border_q <= s3_border_q;
      s4_last_q   <= s3_last_q;
    end
  end

  // output register
  pix_t      abs_diff;
  out_beat_t out_data_q;

  assign abs_diff = (s4_mean_q >= s4_center_q) ? (s4_mean_q - s4_center_q)
                                               : (s4_center_q - s4_mean_q);

  always_ff @(posedge clk_i) begin
    if (mv4o) begin
      out_data_q.detail        <= s4_border_q ? s4_center_q : abs_diff;
      out_data_q.last_of_frame <= s4_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RST_WIDTH;
      height_q    <= RST_HEIGHT;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (go1) begin
        s1_valid_q <= accept;
      end
      if (go2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (go3) begin
        s3_valid_q <= s2_valid_q && s2_flags_q.emit;
      end
      if (go4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (go_out) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

endmodule

>>> hdl/box3dm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module box3dm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/box3dm_cell.sv
// One window column: holds three pixels, hands them to its neighbor on shift.
// Depends on box3dm_pkg.
`timescale 1ns / 1ps

module box3dm_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  box3dm_pkg::col_t  col_i,
  output box3dm_pkg::col_t  col_o,
  output logic [box3dm_pkg::CSUM_W-1:0] sum_o
);
  import box3dm_pkg::*;

  col_t col_q, col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;
  assign sum_o = CSUM_W'(col_q.top) + CSUM_W'(col_q.mid) + CSUM_W'(col_q.bot);

endmodule

>>> hdl/box3dm_sva.sv
// Port-level checker of the 3x3 detail mask block, bound to the top level.
// Depends on box3dm_pkg and box3x3_detail_mask_assert.svh.
`timescale 1ns / 1ps
`include "box3x3_detail_mask_assert.svh"

module box3dm_sva (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input box3dm_pkg::out_beat_t                out_data_o,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [box3dm_pkg::PADDR_W-1:0]       paddr,
  input logic [box3dm_pkg::DATA_W-1:0]        pwdata,
  input logic [box3dm_pkg::DATA_W-1:0]        prdata,
  input logic                                 pready
);
  import box3dm_pkg::*;

  logic               cfg_we, out_stall, low_dim_we, clamp_ok;
  logic [PADDR_W-1:0] paddr_q;

  assign cfg_we     = psel && penable && pwrite && pready;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign low_dim_we = cfg_we && (pwdata[DIM_W-1:0] < DIM_MIN);
  assign clamp_ok   = (paddr != paddr_q) || (prdata == DATA_W'(DIM_MIN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paddr_q <= '0;
    end else begin
      paddr_q <= paddr;
    end
  end

  `BOX3DM_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "out beat dropped in stall")
  `BOX3DM_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_data_o), "out beat changed in stall")
  `BOX3DM_ASSERT_SAME(a_ready_when_empty, !out_valid_o, in_ready_o, "in_ready low, output empty")
  `BOX3DM_ASSERT_NEXT(a_cfg_low_clamp, low_dim_we, clamp_ok, "small dimension not raised")

endmodule

bind box3x3_detail_mask box3dm_sva u_box3dm_sva (.*);

>>> test/box3x3_detail_mask_test.sv
// Self-checking testbench of box3x3_detail_mask: random and directed pixel frames
// on valid/ready, geometry through the APB port, results checked against a predictor.
// Depends on box3dm_pkg and the box3x3_detail_mask RTL.
`timescale 1ns / 1ps

module box3x3_detail_mask_test;
  import box3dm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned CALM_ITEMS    = 120;
  localparam int unsigned BOX_AREA      = BOX_N * BOX_N;
  localparam int unsigned ROW_CAP       = (1 << ROW_W) - 1;
  localparam int unsigned WHOLE_FRAME   = 32'hFFFF_FFFF;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  out_beat_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  in_beat_t    pixel_feed[$];
  out_beat_t   pending_details[$];

  pix_t        line_up [MAX_WIDTH];
  pix_t        line_two_up [MAX_WIDTH];
  pix_t        win [BOX_AREA];
  int unsigned col_pos, row_pos, frame_count, cfg_width, cfg_height;

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned beats_in      = 0;
  int unsigned pads_in       = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_seen   = 0;
  int unsigned config_writes = 0;
  int unsigned feed_gap      = 0;
  int unsigned sink_gap      = 0;
  logic        feed_took     = 1'b0;
  logic        calm          = 1'b0;

  box3x3_detail_mask uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5ns clk_i = ~clk_i;

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    frame_count = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic void reset_model();
    foreach (line_up[i]) begin
      line_up[i] = '0;
      line_two_up[i] = '0;
    end
    cfg_width = RST_WIDTH;
    cfg_height = RST_HEIGHT;
    restart_frame();
  endfunction

  function automatic void set_dim(logic sel, logic [DATA_W-1:0] value);
    int unsigned v, hi;
    v = value[DIM_W-1:0];
    hi = (sel == REG_WIDTH) ? MAX_WIDTH : MAX_HEIGHT;
    if (v < DIM_MIN) v = DIM_MIN;
    else if (v > hi) v = hi;
    if (sel == REG_WIDTH) cfg_width = v;
    else cfg_height = v;
    restart_frame();
  endfunction

  // shift the window by one column and emit the mask value it completes, if any
  function automatic void mask_pixel(in_beat_t beat);
    pix_t        v, top, mid, wrap, center, detail;
    int unsigned c, r, cr, cc, sum, mean, total;
    out_beat_t   res;
    v = beat.is_pad ? '0 : beat.pixel;
    c = col_pos;
    r = row_pos;
    wrap = line_two_up[cfg_width - 1];
    top = line_two_up[c];
    mid = line_up[c];
    line_two_up[c] = mid;
    line_up[c] = v;
    for (int i = 0; i < BOX_N; i++) begin
      win[i * BOX_N + 0] = win[i * BOX_N + 1];
      win[i * BOX_N + 1] = win[i * BOX_N + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    if ((r >= 1 && c >= 1) || (r >= 2 && c == 0)) begin
      total = cfg_width * cfg_height;
      if (frame_count < total) begin
        if (c >= 1) begin
          cr = r - 1;
          cc = c - 1;
          center = win[BOX_AREA / 2];
        end else begin
          cr = r - 2;
          cc = cfg_width - 1;
          center = wrap;
        end
        if (cr == 0 || cr >= cfg_height - 1 || cc == 0 || cc >= cfg_width - 1) begin
          detail = center;
        end else begin
          sum = 0;
          foreach (win[i]) sum += win[i];
          mean = sum / BOX_AREA;
          detail = pix_t'((mean >= center) ? mean - center : center - mean);
        end
        frame_count++;
        res.detail = detail;
        res.last_of_frame = (frame_count == total);
        pending_details.push_back(res);
        if (res.last_of_frame) begin
          restart_frame();
          return;
        end
      end
    end
    c++;
    if (c >= cfg_width) begin
      c = 0;
      if (r < ROW_CAP) r++;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // random pixels with sparse pads, then the drain beats; stop early at stop_at
  function automatic int unsigned queue_frame(int unsigned w, int unsigned h,
                                              int unsigned stop_at);
    in_beat_t    b;
    int unsigned n;
    n = w * h + w + 1;
    if (stop_at < n) n = stop_at;
    for (int unsigned k = 0; k < n; k++) begin
      b.pixel = pix_t'($urandom_range(0, 255));
      b.is_pad = (k >= w * h) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
      pixel_feed.push_back(b);
    end
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] pick_dim();
    int unsigned roll, v;
    roll = $urandom_range(0, 19);
    if (roll == 0) v = $urandom_range(0, 2);
    else if (roll == 1) v = $urandom_range(1025, 2047);
    else if (roll < 5) v = $urandom_range(3, 40);
    else v = $urandom_range(3, 12);
    return ($urandom() & ~32'h7FF) | v;
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pixel_feed.size() != 0 || in_valid_i || pending_details.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({sel, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    set_dim(sel, value);
    config_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    #1;
  endtask

  always @(negedge clk_i) begin : feed
    if (rst_ni && (!in_valid_i || feed_took)) begin
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        feed_gap = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else if (pixel_feed.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pixel_feed.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : sink
    if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch
    out_beat_t want;
    feed_took <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      mask_pixel(in_data_i);
      beats_in++;
      if (in_data_i.is_pad) pads_in++;
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_details.size() == 0) begin
        $error("result beat with nothing expected: detail %0d last_of_frame %0d",
               out_data_o.detail, out_data_o.last_of_frame);
        error_count++;
      end else begin
        want = pending_details.pop_front();
        results_seen++;
        if (want.last_of_frame) frames_seen++;
        if (out_data_o.detail !== want.detail) begin
          $error("detail: expected %0d, got %0d", want.detail, out_data_o.detail);
          error_count++;
        end
        if (out_data_o.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0d, got %0d",
                 want.last_of_frame, out_data_o.last_of_frame);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("box3x3_detail_mask_test: errors");
    $finish;
  end

  initial begin : stimulus
    in_beat_t    b;
    int unsigned pick, total, stop_at, fed_random;
    logic        need_config;
    reset_model();
    fed_random = 0;
    need_config = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: partial frame, then abandon it
    void'(queue_frame(cfg_width, cfg_height, 1030));
    wait_idle();

    // smallest frame, extreme pixels, non-pad drain, then pad inside frame and pad drain
    write_reg(REG_WIDTH, 32'hFFFF_F800);
    write_reg(REG_HEIGHT, 32'd2);
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < 13; k++) begin
        if (k >= 9) b.pixel = (f == 0) ? 8'hFF : 8'h5A;
        else b.pixel = ((k == 4) ^ (f == 0)) ? 8'hFF : 8'h00;
        b.is_pad = (f == 1) && (k == 1 || k >= 9);
        if (f == 1 && k == 1) b.pixel = 8'hFF;
        pixel_feed.push_back(b);
      end
    end
    wait_idle();

    // restart in the middle of a frame
    write_reg(REG_WIDTH, 32'hABCD_0005);
    write_reg(REG_HEIGHT, 32'd4);
    void'(queue_frame(cfg_width, cfg_height, 12));
    wait_idle();
    write_reg(REG_HEIGHT, 32'd4);
    void'(queue_frame(cfg_width, cfg_height, WHOLE_FRAME));
    wait_idle();

    // widest and tallest geometries
    write_reg(REG_WIDTH, 32'h0000_07FF);
    write_reg(REG_HEIGHT, 32'd1);
    void'(queue_frame(cfg_width, cfg_height, 40));
    wait_idle();
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'h0000_07FF);
    void'(queue_frame(cfg_width, cfg_height, 120));
    wait_idle();

    while (fed_random < RANDOM_ITEMS) begin
      if (fed_random + CALM_ITEMS >= RANDOM_ITEMS) calm = 1'b1;
      if (need_config || $urandom_range(0, 3) == 0) begin
        wait_idle();
        pick = $urandom_range(0, 2);
        if (pick != 1) write_reg(REG_WIDTH, pick_dim());
        if (pick != 0) write_reg(REG_HEIGHT, pick_dim());
        need_config = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        wait_idle();
      end
      total = cfg_width * cfg_height + cfg_width + 1;
      stop_at = total;
      if (cfg_width * cfg_height > 400 || $urandom_range(0, 7) == 0) begin
        stop_at = $urandom_range(1, (total > 300) ? 300 : total - 1);
        need_config = 1'b1;
      end
      fed_random += queue_frame(cfg_width, cfg_height, stop_at);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (pending_details.size() != 0) begin
      $error("%0d expected results never arrived", pending_details.size());
      error_count++;
    end
    $display("Covered %0d pixel beats (%0d pads) over %0d register writes;",
             beats_in, pads_in, config_writes);
    $display("checked %0d mask results, %0d frames closed.", results_seen, frames_seen);
    if (error_count == 0) begin
      $display("box3x3_detail_mask_test: clean");
    end else begin
      $display("box3x3_detail_mask_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/box3dm_pkg.sv
hdl/box3dm_ram.sv
hdl/box3dm_cell.sv
hdl/box3x3_detail_mask.sv
hdl/box3dm_sva.sv
test/box3x3_detail_mask_test.sv
